// ===== hw/rtl/dttfp_pkg.sv =====
`default_nettype none

package dttfp_pkg;

    // Character codes the parser reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Result format: Q31.32
    localparam int VALUE_W  = 64;
    localparam int Q_FRAC   = 32;
    // Headroom bits above the value for the unclamped sum
    localparam int SUM_W    = VALUE_W + 2;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 64'sh8000_0000_0000_0000;

    typedef logic [7:0]                t_char;
    typedef logic signed [VALUE_W-1:0] t_value;

endpackage

`default_nettype wire

// ===== hw/rtl/decimal_text_to_fixed_point.sv =====
`default_nettype none

// Decimal text to signed Q31.32 fixed point. One character is taken per beat,
// one every clock cycle while o_stall is low; a zero byte closes the string, and
// its result passes a sum-and-clamp stage, then a negate-and-clamp stage, to the
// output; once the zero byte is taken, the parser is already clear for the next
// string. Leading whitespace is skipped, each '-' in the sign run flips the
// sign, digits up to a dot build a saturating INT_BITS integer part, and each
// later character adds (code - '0') times a weight from a constant table of
// tenths with WEIGHT_FRAC_BITS fraction bits. o_overflow reports integer
// saturation or clamping of the final value. The input stalls only when both
// output stages hold results that downstream has not taken.
module decimal_text_to_fixed_point #(
    parameter int WEIGHT_FRAC_BITS = 48,
    parameter int INT_BITS         = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  dttfp_pkg::t_char     i_char_code,
    output logic                 o_valid,
    input  wire                  i_stall,
    output dttfp_pkg::t_value    o_value,
    output logic                 o_overflow
);
    import dttfp_pkg::*;

    localparam int W       = WEIGHT_FRAC_BITS;
    localparam int FRAC_W  = W + 9;          // fraction accumulator
    localparam int FQ_W    = Q_FRAC + 9;     // fraction at 32 fraction bits
    localparam int AW      = INT_BITS + 5;   // acc*10 + digit before clamp
    localparam int SH      = (W > Q_FRAC) ? W - Q_FRAC : 0;
    localparam int HALF_SH = (W > Q_FRAC) ? W - Q_FRAC - 1 : 0;

    function automatic int weight_count();
        logic [63:0] w;
        int          n;
        w = ((64'd1 << W) + 64'd5) / 64'd10;
        n = 1;
        for (int k = 0; k < 32; k++) begin
            if (w != 64'd0) begin
                w = w / 64'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int NW   = weight_count();
    localparam int WI_W = $clog2(NW);

    function automatic logic [NW*W-1:0] build_weights();
        logic [63:0]     w;
        logic [NW*W-1:0] tab;
        w   = ((64'd1 << W) + 64'd5) / 64'd10;
        tab = '0;
        for (int k = 0; k < NW; k++) begin
            tab[k*W +: W] = w[W-1:0];
            w = w / 64'd10;
        end
        return tab;
    endfunction

    localparam logic [NW*W-1:0] WTAB = build_weights();

    // Rounding offset folded into the accumulator's reset value
    localparam logic signed [FRAC_W-1:0] FRAC_RST = (W > Q_FRAC) ?
        ({{(FRAC_W-1){1'b0}}, 1'b1} << HALF_SH) : '0;

    localparam logic signed [AW-1:0] IMAX =
        {{(AW-INT_BITS+1){1'b0}}, {(INT_BITS-1){1'b1}}};
    localparam logic signed [AW-1:0] IMIN = ~IMAX;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(VALUE_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(VALUE_MIN);

    typedef enum logic [1:0] {
        PH_WS,
        PH_SIGN,
        PH_INT,
        PH_FRAC
    } t_phase;

    // Parser state
    t_phase                     r_phase, n_phase;
    logic                       r_neg, n_neg;
    logic signed [INT_BITS-1:0] r_int, n_int;
    logic signed [FRAC_W-1:0]   r_frac, n_frac;
    logic [WI_W-1:0]            r_widx, n_widx;
    logic                       r_sat, n_sat;

    // Sum stage and output stage
    logic                       r_s1_valid;
    logic signed [SUM_W-1:0]    r_s1_sum;
    logic                       r_s1_neg;
    logic                       r_s1_ovf;
    logic                       r_out_valid;
    t_value                     r_value;
    logic                       r_ovf;

    logic                       accept;
    logic                       is_nul;
    logic                       out_free;
    logic                       s1_adv;
    logic signed [8:0]          digit;
    logic [W-1:0]               weight;
    logic signed [W+9:0]        fprod;
    logic signed [AW-1:0]       iacc;
    logic signed [FQ_W-1:0]     fq;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_clamped;
    logic                       sum_ovf;
    t_value                     neg_value;
    logic                       neg_ovf;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign accept   = i_valid && !o_stall;
    assign is_nul   = (i_char_code == CH_NUL);

    assign digit  = signed'({1'b0, i_char_code}) - signed'({1'b0, CH_ZERO});
    assign weight = WTAB[r_widx*W +: W];
    assign fprod  = digit * signed'({1'b0, weight});
    assign iacc   = (AW'(r_int) <<< 3) + (AW'(r_int) <<< 1) + AW'(digit);

    // Parse one non-terminating character; phases fall through like the scan
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_int   = r_int;
        n_frac  = r_frac;
        n_widx  = r_widx;
        n_sat   = r_sat;
        if (r_phase == PH_FRAC) begin
            n_frac = r_frac + signed'(fprod[FRAC_W-1:0]);
            if (r_widx != WI_W'(NW - 1)) begin
                n_widx = r_widx + 1'b1;
            end
        end else begin
            priority if (r_phase == PH_WS &&
                         ((i_char_code >= CH_TAB && i_char_code <= CH_CR) ||
                          i_char_code == CH_SPACE)) begin
                n_phase = PH_WS;
            end else if (r_phase != PH_INT &&
                         (i_char_code == CH_PLUS || i_char_code == CH_MINUS)) begin
                n_phase = PH_SIGN;
                n_neg   = r_neg ^ (i_char_code == CH_MINUS);
            end else if (i_char_code == CH_DOT) begin
                n_phase = PH_FRAC;
            end else begin
                n_phase = PH_INT;
                priority if (iacc > IMAX) begin
                    n_int = IMAX[INT_BITS-1:0];
                    n_sat = 1'b1;
                end else if (iacc < IMIN) begin
                    n_int = IMIN[INT_BITS-1:0];
                    n_sat = 1'b1;
                end else begin
                    n_int = iacc[INT_BITS-1:0];
                end
            end
        end
    end

    // Fraction at 32 fraction bits: floor of the offset accumulator
    generate
        if (W >= Q_FRAC) begin : g_frac_down
            logic signed [FRAC_W-1:0] frac_sh;
            assign frac_sh = r_frac >>> SH;
            assign fq      = signed'(frac_sh[FQ_W-1:0]);
        end else begin : g_frac_up
            assign fq = signed'({r_frac, {(Q_FRAC-W){1'b0}}});
        end
    endgenerate

    assign sum = (SUM_W'(r_int) <<< Q_FRAC) + SUM_W'(fq);

    always_comb begin
        sum_ovf = 1'b0;
        priority if (sum > SUM_MAX) begin
            sum_clamped = SUM_MAX;
            sum_ovf     = 1'b1;
        end else if (sum < SUM_MIN) begin
            sum_clamped = SUM_MIN;
            sum_ovf     = 1'b1;
        end else begin
            sum_clamped = sum;
        end
    end

    always_comb begin
        neg_ovf   = r_s1_ovf;
        neg_value = r_s1_sum[VALUE_W-1:0];
        if (r_s1_neg) begin
            if (r_s1_sum[VALUE_W-1:0] == VALUE_MIN) begin
                neg_value = VALUE_MAX;
                neg_ovf   = 1'b1;
            end else begin
                neg_value = -r_s1_sum[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WS;
            r_neg       <= 1'b0;
            r_int       <= '0;
            r_frac      <= FRAC_RST;
            r_widx      <= '0;
            r_sat       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (is_nul) begin
                    // close the string and clear for the next one
                    r_phase <= PH_WS;
                    r_neg   <= 1'b0;
                    r_int   <= '0;
                    r_frac  <= FRAC_RST;
                    r_widx  <= '0;
                    r_sat   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_int   <= n_int;
                    r_frac  <= n_frac;
                    r_widx  <= n_widx;
                    r_sat   <= n_sat;
                end
            end

            if (accept && is_nul) begin
                r_s1_valid <= 1'b1;
                r_s1_sum   <= sum_clamped;
                r_s1_neg   <= r_neg;
                r_s1_ovf   <= r_sat | sum_ovf;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_value     <= neg_value;
                r_ovf       <= neg_ovf;
            end else if (!i_stall) begin
                // drop the beat once taken
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_value;
    assign o_overflow = r_ovf;

endmodule

`default_nettype wire

// ===== verif/number_checker.sv =====
`timescale 1ns / 1ps

module number_checker #(
    parameter int WEIGHT_FRAC_BITS = 48,
    parameter int INT_BITS         = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_stall,
    input  dttfp_pkg::t_char  i_char_code,
    input  wire               i_out_valid,
    input  wire               i_out_stall,
    input  dttfp_pkg::t_value i_value,
    input  wire               i_overflow,
    output int                o_fail_count,
    output int                o_waiting_count
);
    import dttfp_pkg::*;

    typedef enum logic [1:0] {PH_SPACE, PH_SIGN, PH_INT, PH_FRAC} t_parse_phase;

    typedef struct packed {
        t_value value;
        logic   overflow;
    } t_number;

    localparam longint unsigned TENTH = ((64'd1 << WEIGHT_FRAC_BITS) + 64'd5) / 64'd10;
    localparam longint INT_TOP = (longint'(1) << (INT_BITS - 1)) - 1;
    localparam longint INT_BOT = -INT_TOP - 1;
    localparam longint SUM_TOP = VALUE_MAX;
    localparam longint SUM_BOT = VALUE_MIN;

    t_parse_phase    phase;
    bit              negative;
    longint          int_acc;
    longint          frac_acc;
    longint unsigned weight;
    bit              saturated;

    t_number expected_numbers[$];
    int      fails = 0;

    function void clear_parser();
        phase     = PH_SPACE;
        negative  = 1'b0;
        int_acc   = 0;
        frac_acc  = 0;
        weight    = TENTH;
        saturated = 1'b0;
    endfunction

    // Round to nearest, ties toward plus infinity, down to Q_FRAC fraction bits
    function automatic longint frac_in_q32(input longint f);
        int     sh;
        longint v;
        if (WEIGHT_FRAC_BITS < Q_FRAC) return f * (longint'(1) << (Q_FRAC - WEIGHT_FRAC_BITS));
        sh = WEIGHT_FRAC_BITS - Q_FRAC;
        if (sh == 0) return f;
        v = f + (longint'(1) << (sh - 1));
        return v >>> sh;
    endfunction

    function automatic bit parse_char(input t_char c, output t_number num);
        longint d;
        longint prod;
        longint f;
        longint total;
        longint a;
        bit     ovf;
        num = '0;
        d = longint'(c) - longint'(CH_ZERO);
        if (c == CH_NUL) begin
            prod  = int_acc * (longint'(1) << Q_FRAC);
            f     = frac_in_q32(frac_acc);
            ovf   = saturated;
            if (f > 0 && prod > SUM_TOP - f) begin
                total = SUM_TOP;
                ovf   = 1'b1;
            end else if (f < 0 && prod < SUM_BOT - f) begin
                total = SUM_BOT;
                ovf   = 1'b1;
            end else begin
                total = prod + f;
            end
            if (negative) begin
                if (total == SUM_BOT) begin
                    total = SUM_TOP;
                    ovf   = 1'b1;
                end else begin
                    total = -total;
                end
            end
            num.value    = total;
            num.overflow = ovf;
            clear_parser();
            return 1'b1;
        end
        if (phase == PH_SPACE) begin
            if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) return 1'b0;
            phase = PH_SIGN;
        end
        if (phase == PH_SIGN) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
                if (c == CH_MINUS) negative = !negative;
                return 1'b0;
            end
            phase = PH_INT;
        end
        if (phase == PH_INT) begin
            if (c == CH_DOT) begin
                phase = PH_FRAC;
                return 1'b0;
            end
            a = int_acc * 10 + d;
            if (a > INT_TOP) begin
                a = INT_TOP;
                saturated = 1'b1;
            end else if (a < INT_BOT) begin
                a = INT_BOT;
                saturated = 1'b1;
            end
            int_acc = a;
            return 1'b0;
        end
        // anything past the dot counts, a second dot and non-digits too
        frac_acc = frac_acc + d * longint'(weight);
        weight   = weight / 10;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_number num;
        if (!i_rst_n) begin
            clear_parser();
            expected_numbers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_numbers.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got value %h overflow %b",
                             $time, i_value, i_overflow);
                    fails++;
                end else begin
                    num = expected_numbers.pop_front();
                    if (i_value !== num.value) begin
                        $display("%0t: value mismatch: expected %h, got %h",
                                 $time, num.value, i_value);
                        fails++;
                    end
                    if (i_overflow !== num.overflow) begin
                        $display("%0t: overflow mismatch: expected %b, got %b",
                                 $time, num.overflow, i_overflow);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (parse_char(i_char_code, num)) expected_numbers.push_back(num);
            end
        end
        o_fail_count    <= fails;
        o_waiting_count <= expected_numbers.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dttfp_pkg::*;

    localparam int TEXT_CHARS  = 1700;
    localparam int CYCLE_LIMIT = 400000;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_valid     = 1'b0;
    logic   o_stall;
    t_char  i_char_code = CH_NUL;
    logic   o_valid;
    logic   i_stall     = 1'b0;
    t_value o_value;
    logic   o_overflow;

    int fail_count;
    int waiting_count;
    int chars_sent      = 0;
    int cycle_count     = 0;
    bit quiet           = 1'b0;
    bit gap_calm        = 1'b0;
    int gap_calm_left   = 100;
    int stall_left      = 0;
    bit stall_calm      = 1'b0;
    int stall_calm_left = 150;

    decimal_text_to_fixed_point dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_overflow  (o_overflow)
    );

    number_checker number_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_char_code     (i_char_code),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_value         (o_value),
        .i_overflow      (o_overflow),
        .o_fail_count    (fail_count),
        .o_waiting_count (waiting_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output backpressure in bursts, with calm stretches in between
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0 && !stall_calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 17);
            i_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
            stall_calm_left--;
            if (stall_calm_left <= 0) begin
                stall_calm      = !stall_calm;
                stall_calm_left = $urandom_range(40, 300);
            end
        end
    end

    task automatic send_char(input t_char c);
        int gap;
        gap_calm_left--;
        if (gap_calm_left <= 0) begin
            gap_calm      = !gap_calm;
            gap_calm_left = $urandom_range(30, 200);
        end
        if (!quiet && !gap_calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        // hold the beat until it is taken
        while (o_stall) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input t_char text[$]);
        foreach (text[k]) send_char(text[k]);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (waiting_count != 0) @(posedge i_clk);
    endtask

    initial begin
        t_char text[$];
        int    mode;
        int    n;
        int    k;
        bit    drained_mid;
        drained_mid = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty string
        text = '{CH_NUL};
        send_text(text);
        // whitespace, signs, digit, dot, top byte in the fraction, second dot
        text = '{CH_TAB, CH_CR, CH_SPACE, CH_PLUS, CH_MINUS, t_char'(CH_ZERO + 8'd7), CH_DOT,
                 8'hFF, CH_DOT, t_char'(CH_ZERO + 8'd9), CH_NUL};
        send_text(text);
        // integer part driven to the negative limit, then negation clamps
        text = '{CH_MINUS};
        repeat (10) text.push_back(8'h01);
        text.push_back(CH_DOT);
        text.push_back(8'h01);
        text.push_back(CH_NUL);
        send_text(text);
        drain_results();

        while (chars_sent < TEXT_CHARS) begin
            text.delete();
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                n = $urandom_range(0, 20);
                repeat (n) text.push_back(t_char'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    k = $urandom_range(0, 5);
                    text.push_back(k < 5 ? t_char'(CH_TAB + k) : CH_SPACE);
                end
                repeat ($urandom_range(0, 3))
                    text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                // long integer runs can reach saturation
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
                repeat (n) text.push_back(t_char'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 4) != 0) begin
                    text.push_back(CH_DOT);
                    // long fractions run the weight down to zero
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 22)
                                                    : $urandom_range(0, 8);
                    repeat (n) text.push_back(t_char'(CH_ZERO + $urandom_range(0, 9)));
                end
                if (mode == 1)
                    text.insert($urandom_range(0, text.size()),
                                t_char'($urandom_range(1, 255)));
            end
            text.push_back(CH_NUL);
            send_text(text);
            if (!drained_mid && chars_sent >= TEXT_CHARS / 2) begin
                drained_mid = 1'b1;
                drain_results();
            end
            if (chars_sent >= TEXT_CHARS * 85 / 100) quiet <= 1'b1;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== decimal_text_to_fixed_point.f =====
hw/rtl/dttfp_pkg.sv
hw/rtl/decimal_text_to_fixed_point.sv
verif/number_checker.sv
verif/testbench.sv
